// ===== hw/rtl/ple_pkg.sv =====
// Shared constants and types for the positional list engine.
// No dependencies; the interfaces and the engine refer to this package by scoped names.
`default_nettype none

package ple_pkg;

    // List storage geometry.
    localparam int unsigned DEPTH      = 16;
    localparam int unsigned ITEM_WIDTH = 32;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);

    // Fixed field widths of the command and response transfers.
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned FPOS_W = 4;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Command codes carried in the cmd field.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_FIND   = 3'd5
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ple_cmd_if.sv =====
// Command channel of the positional list engine: valid/ready plus the command payload.
// Depends on ple_pkg for the field widths.
`default_nettype none

interface ple_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [ple_pkg::CMD_W-1:0]      cmd;
    logic [ple_pkg::POS_W-1:0]      position;
    logic [ple_pkg::ITEM_WIDTH-1:0] value;

    modport source (output valid, cmd, position, value, input ready);
    modport sink   (input valid, cmd, position, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ple_rsp_if.sv =====
// Response channel of the positional list engine: valid/ready plus the result payload.
// Depends on ple_pkg for the field widths.
`default_nettype none

interface ple_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [ple_pkg::ITEM_WIDTH-1:0] item_out;
    logic [ple_pkg::FPOS_W-1:0]     found_position;
    logic [ple_pkg::CNT_W-1:0]      count;

    modport source (output valid, ok, item_out, found_position, count, input ready);
    modport sink   (input valid, ok, item_out, found_position, count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ple_ram.sv =====
// Generic RAM with one write port and one read port; read data is registered.
// Stand-alone; no package dependencies.
`default_nettype none

module ple_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same address is written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_engine.sv =====
// Push/insert at position p shift the entries from p onward up one slot, then write the new
// item (no shift when appending); pop/delete shift the later entries down one slot; read
// fetches the entry from RAM; find walks the list from the front until it finds a match or
// reaches the end; a rejected command or an unused code goes straight to the response. One
// command at a time; shifts walk the single-write, single-read list RAM, one entry per cycle.
// Reset: asynchronous, active low; the list empties, the sequencer idles, RAM is not cleared.
`default_nettype none

module positional_list_engine (
    input wire logic clk,
    input wire logic rst_n,
    ple_cmd_if.sink  cmd_ch,
    ple_rsp_if.source rsp_ch
);

    localparam int unsigned AW  = ple_pkg::ADDR_W;
    localparam int unsigned CW  = ple_pkg::CNT_W;
    localparam int unsigned IW  = ple_pkg::ITEM_WIDTH;

    // The sequencer walks the RAM one entry per cycle. Shifts are pipelined: the read of
    // one entry is issued while the entry read in the previous cycle is written one slot
    // further along, so a pending write always takes its data straight from the RAM output.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_DRAIN,
        S_FILL,
        S_DOWN,
        S_DOWN_DRAIN,
        S_READ,
        S_READ_WAIT,
        S_FIND,
        S_RESP
    } state_t;

    state_t            state_reg,   state_next;
    logic [CW-1:0]     count_reg,   count_next;
    logic [CW-1:0]     src_reg,     src_next;
    logic [CW-1:0]     pos_reg,     pos_next;
    logic [CW-1:0]     last_reg,    last_next;
    logic [IW-1:0]     val_reg,     val_next;
    logic              pend_reg,    pend_next;
    logic [AW-1:0]     wa_reg,      wa_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              ok_reg,      ok_next;
    logic [IW-1:0]     item_reg,    item_next;
    logic [ple_pkg::FPOS_W-1:0] fpos_reg, fpos_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [IW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [IW-1:0]     ram_rdata;

    logic              cmd_xfer;
    logic              rsp_xfer;
    logic [CW-1:0]     req_pos;

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign cmd_xfer     = cmd_ch.valid && cmd_ch.ready;
    assign rsp_ch.valid = (state_reg == S_RESP);
    assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;

    assign rsp_ch.ok             = ok_reg;
    assign rsp_ch.item_out       = item_reg;
    assign rsp_ch.found_position = fpos_reg;
    assign rsp_ch.count          = count_reg;

    // Push and pop act on the front of the list, which is position zero.
    always_comb
    begin
        if (cmd_ch.cmd == ple_pkg::CMD_PUSH || cmd_ch.cmd == ple_pkg::CMD_POP)
        begin
            req_pos = '0;
        end
        else
        begin
            req_pos = CW'(cmd_ch.position);
        end
    end

    // RAM port control. A pending shift write and the final fill never overlap,
    // since the drain state always sits between them.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;
        if (pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_FILL)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg[AW-1:0];
            ram_wdata = val_reg;
        end
    end

    always_comb
    begin
        if (state_reg == S_READ)
        begin
            ram_raddr = pos_reg[AW-1:0];
        end
        else
        begin
            ram_raddr = src_reg[AW-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        src_next     = src_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        val_next     = val_reg;
        pend_next    = 1'b0;
        wa_next      = wa_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        ok_next      = ok_reg;
        item_next    = item_reg;
        fpos_next    = fpos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    ok_next   = 1'b0;
                    item_next = '0;
                    fpos_next = '0;
                    pos_next  = req_pos;
                    val_next  = cmd_ch.value;
                    src_next  = '0;
                    state_next = S_RESP;
                    unique case (cmd_ch.cmd)
                        ple_pkg::CMD_PUSH, ple_pkg::CMD_INSERT:
                        begin
                            if (count_reg < ple_pkg::DEPTH_CNT && req_pos <= count_reg)
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (count_reg > req_pos)
                                begin
                                    src_next   = count_reg - CW'(1);
                                    state_next = S_UP;
                                end
                                else
                                begin
                                    state_next = S_FILL;
                                end
                            end
                        end
                        ple_pkg::CMD_POP, ple_pkg::CMD_DELETE:
                        begin
                            if (req_pos < count_reg)
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg - CW'(1);
                                if (req_pos + CW'(1) < count_reg)
                                begin
                                    src_next   = req_pos + CW'(1);
                                    last_next  = count_reg - CW'(1);
                                    state_next = S_DOWN;
                                end
                            end
                        end
                        ple_pkg::CMD_READ:
                        begin
                            if (req_pos < count_reg)
                            begin
                                ok_next    = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        ple_pkg::CMD_FIND:
                        begin
                            state_next = S_FIND;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // Move entry src up one slot; the last one moved is the target position.
                pend_next = 1'b1;
                wa_next   = AW'(src_reg + CW'(1));
                if (src_reg == pos_reg)
                begin
                    state_next = S_UP_DRAIN;
                end
                else
                begin
                    src_next = src_reg - CW'(1);
                end
            end
            S_UP_DRAIN:
            begin
                state_next = S_FILL;
            end
            S_FILL:
            begin
                state_next = S_RESP;
            end
            S_DOWN:
            begin
                pend_next = 1'b1;
                wa_next   = AW'(src_reg - CW'(1));
                if (src_reg == last_reg)
                begin
                    state_next = S_DOWN_DRAIN;
                end
                else
                begin
                    src_next = src_reg + CW'(1);
                end
            end
            S_DOWN_DRAIN:
            begin
                state_next = S_RESP;
            end
            S_READ:
            begin
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                item_next  = ram_rdata;
                state_next = S_RESP;
            end
            S_FIND:
            begin
                // Reads run one entry ahead of the comparison against the searched value.
                priority if (cmp_vld_reg && ram_rdata == val_reg)
                begin
                    ok_next    = 1'b1;
                    fpos_next  = ple_pkg::FPOS_W'(cmp_idx_reg);
                    state_next = S_RESP;
                end
                else if (src_reg < count_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = src_reg[AW-1:0];
                    src_next     = src_reg + CW'(1);
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_xfer)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg     <= src_next;
        pos_reg     <= pos_next;
        last_reg    <= last_next;
        val_reg     <= val_next;
        wa_reg      <= wa_next;
        cmp_idx_reg <= cmp_idx_next;
        ok_reg      <= ok_next;
        item_reg    <= item_next;
        fpos_reg    <= fpos_next;
    end

    ple_ram #(
        .WIDTH (IW),
        .DEPTH (ple_pkg::DEPTH)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The count can never exceed the list capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::DEPTH_CNT)
        else $error("list count exceeds capacity");

    // A shift write must have drained before the new item is written.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && state_reg == S_FILL))
        else $error("shift write collides with fill write");

    // An accepted command keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> !cmd_ch.ready)
        else $error("new command accepted while one is in flight");

    // After a response transfer the block is ready for the next command.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_xfer |=> cmd_ch.ready)
        else $error("block not idle after response transfer");

    // The count changes only in the cycle a command is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd_xfer) |-> $stable(count_reg))
        else $error("count changed outside command acceptance");

endmodule

`default_nettype wire
